### rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; every macro asserts on posedge clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/rsnh_pkg.sv
// shared types and constants of the ray versus wall table block
// no dependencies
`timescale 1ns / 1ps

package rsnh_pkg;

  localparam int COORD_BITS   = 16;
  localparam int SLOTS_DEF    = 256;
  localparam int SLOT_FIELD_W = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RAY  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                    cmd;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    is_wall;
    coord_t                  ax;
    coord_t                  ay;
    coord_t                  bx;
    coord_t                  by;
  } item_t;

  typedef struct packed {
    logic                    hit;
    coord_t                  hit_x;
    coord_t                  hit_y;
    logic [SLOT_FIELD_W-1:0] hit_slot;
  } result_t;

endpackage

### rtl/ray_segment_nearest_hit.sv
// ray versus wall-segment table with nearest-hit search
// depends on rsnh_pkg; one shared multiplier under a sequencer
// load word: written to its slot when taken, the input stays open. ray word: unless zero-length, every
//   slot is read in turn, each wall slot is tested, one that passes is compared with an earlier hit, then
//   any hit point is divided out and the result handed out; one ray word at a time, the input is closed
//   meanwhile. rst: synchronous; afterwards a clearing pass over every slot wipes the table, during
//   which no word is taken
`timescale 1ns / 1ps

module ray_segment_nearest_hit #(
  parameter int SLOTS = rsnh_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rsnh_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_stall,
  output rsnh_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);

  localparam int CW     = rsnh_pkg::COORD_BITS;
  localparam int DW     = CW + 1;          // coordinate differences
  localparam int HW     = CW + 1;          // half of a magnitude for partial products
  localparam int MW     = CW + 2;          // multiplier operand
  localparam int PW     = 2 * MW;          // multiplier product
  localparam int XW     = 2 * CW + 3;      // signed cross product
  localparam int MAG_W  = 2 * HW;          // cross product magnitude
  localparam int ACC_W  = 2 * MAG_W + 1;   // compare accumulator
  localparam int NUM_W  = HW + MAG_W;      // dividend of the hit point
  localparam int QB     = CW;              // quotient bits
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W  = 1 + 4 * CW;
  localparam int STEP_W = $clog2(CW + 9);
  localparam int SW_W   = rsnh_pkg::SLOT_FIELD_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_PREP, S_CROSS, S_TEST, S_COMPARE, S_DECIDE,
    S_FINAL, S_SCALE, S_DIV, S_EMIT
  } state_t;

  state_t state;
  logic [SLOT_W-1:0] idx;
  logic [STEP_W-1:0] step;

  // ray registers
  logic signed [CW-1:0] ray_x, ray_y;
  logic signed [DW-1:0] dx, dy;

  // current segment
  logic signed [DW-1:0] sx, sy, wx, wy;
  logic signed [XW-1:0] c, tn, un;
  logic [MAG_W-1:0]     cur_t, cur_c;

  // best hit so far
  logic              found;
  logic [MAG_W-1:0]  best_t, best_c;
  logic [SLOT_W-1:0] best_slot;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  logic signed [ACC_W-1:0] acc, term;

  // hit point
  logic              axis;
  logic [NUM_W-1:0]  num, dsor;
  logic [QB-1:0]     quo;
  logic signed [CW-1:0] hx, hy;

  // table memory: {present, x1, y1, x2, y2}
  logic [ENT_W-1:0]  mem [SLOTS];
  logic [ENT_W-1:0]  rd;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [ENT_W-1:0]  mem_wd;

  logic accept;
  logic out_free;
  logic last_slot;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign last_slot  = (idx == SLOT_W'(SLOTS - 1));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && item.cmd == rsnh_pkg::CMD_LOAD && 32'(item.slot) < SLOTS) begin
      mem_we = 1'b1;
      mem_wa = SLOT_W'(item.slot);
      mem_wd = {item.is_wall, item.ax, item.ay, item.bx, item.by};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd <= mem[idx];
  end

  // fields of the word just read
  logic                 rd_present;
  logic signed [CW-1:0] x1, y1, x2, y2;
  assign {rd_present, x1, y1, x2, y2} = rd;

  // sign normalization and range test of the current segment
  logic                 c_neg, seg_ok;
  logic signed [XW-1:0] cn, tnn, unn;
  always_comb begin
    c_neg  = c[XW-1];
    cn     = c_neg ? -c : c;
    tnn    = c_neg ? -tn : tn;
    unn    = c_neg ? -un : un;
    seg_ok = (c != '0) && !tnn[XW-1] && (tnn <= cn) && !unn[XW-1] && (unn <= cn);
  end

  // operand selection for the shared multiplier
  logic [2:0]      k, pk;
  logic [HW-1:0]   lh, rh;
  logic [DW-1:0]   dmag;
  logic            dneg;
  always_comb begin
    k    = step[2:0];
    pk   = 3'(step - STEP_W'(1));
    dneg = axis ? dy[DW-1] : dx[DW-1];
    dmag = axis ? (dneg ? -dy : dy) : (dneg ? -dx : dx);
    if (!k[2]) begin
      lh = k[1] ? cur_t[MAG_W-1:HW] : cur_t[HW-1:0];
      rh = k[0] ? best_c[MAG_W-1:HW] : best_c[HW-1:0];
    end else begin
      lh = k[1] ? best_t[MAG_W-1:HW] : best_t[HW-1:0];
      rh = k[0] ? cur_c[MAG_W-1:HW] : cur_c[HW-1:0];
    end
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_CROSS: begin
        case (step)
          STEP_W'(0): begin mul_a = MW'(dx); mul_b = MW'(sy); end
          STEP_W'(1): begin mul_a = MW'(dy); mul_b = MW'(sx); end
          STEP_W'(2): begin mul_a = MW'(wx); mul_b = MW'(sy); end
          STEP_W'(3): begin mul_a = MW'(wy); mul_b = MW'(sx); end
          STEP_W'(4): begin mul_a = MW'(wx); mul_b = MW'(dy); end
          STEP_W'(5): begin mul_a = MW'(wy); mul_b = MW'(dx); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_COMPARE: begin
        mul_a = {1'b0, lh};
        mul_b = {1'b0, rh};
      end
      S_SCALE: begin
        mul_a = {1'b0, dmag};
        mul_b = step[0] ? {1'b0, best_t[MAG_W-1:HW]} : {1'b0, best_t[HW-1:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // partial product placed at its weight
  logic signed [ACC_W-1:0] term0;
  always_comb begin
    term0 = ACC_W'(prod[2*HW-1:0]);
    if (pk[1] && pk[0]) begin
      term = term0 <<< (2 * HW);
    end else if (pk[1] || pk[0]) begin
      term = term0 <<< HW;
    end else begin
      term = term0;
    end
  end

  // restoring division step
  logic                 ge;
  logic [QB-1:0]        qf;
  logic signed [DW-1:0] off, base;
  always_comb begin
    ge   = (num >= dsor);
    qf   = {quo[QB-2:0], ge};
    off  = dneg ? -DW'(qf) : DW'(qf);
    base = axis ? DW'(ray_y) : DW'(ray_x);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state        <= S_CLEAR;
      idx          <= '0;
      step         <= '0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx + SLOT_W'(1);
          if (last_slot) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && item.cmd == rsnh_pkg::CMD_RAY) begin
            ray_x <= item.ax;
            ray_y <= item.ay;
            dx    <= DW'(item.bx) - DW'(item.ax);
            dy    <= DW'(item.by) - DW'(item.ay);
            found <= 1'b0;
            idx   <= '0;
            if (item.ax == item.bx && item.ay == item.by) begin
              state <= S_EMIT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_PREP;
        end
        S_PREP: begin
          if (rd_present) begin
            sx    <= DW'(x2) - DW'(x1);
            sy    <= DW'(y2) - DW'(y1);
            wx    <= DW'(x1) - DW'(ray_x);
            wy    <= DW'(y1) - DW'(ray_y);
            step  <= '0;
            state <= S_CROSS;
          end else if (last_slot) begin
            state <= S_FINAL;
          end else begin
            idx   <= idx + SLOT_W'(1);
            state <= S_READ;
          end
        end
        S_CROSS: begin
          step <= step + STEP_W'(1);
          case (step)
            STEP_W'(1): c  <= XW'(prod);
            STEP_W'(2): c  <= c - XW'(prod);
            STEP_W'(3): tn <= XW'(prod);
            STEP_W'(4): tn <= tn - XW'(prod);
            STEP_W'(5): un <= XW'(prod);
            STEP_W'(6): begin
              un    <= un - XW'(prod);
              state <= S_TEST;
            end
            default: ;
          endcase
        end
        S_TEST: begin
          cur_t <= MAG_W'(tnn);
          cur_c <= MAG_W'(cn);
          step  <= '0;
          if (seg_ok && found) begin
            state <= S_COMPARE;
          end else begin
            if (seg_ok) begin
              found     <= 1'b1;
              best_t    <= MAG_W'(tnn);
              best_c    <= MAG_W'(cn);
              best_slot <= idx;
            end
            if (last_slot) begin
              state <= S_FINAL;
            end else begin
              idx   <= idx + SLOT_W'(1);
              state <= S_READ;
            end
          end
        end
        S_COMPARE: begin
          // acc = cur_t * best_c - best_t * cur_c, one partial product a cycle
          step <= step + STEP_W'(1);
          if (step != '0) begin
            if (pk[2]) begin
              acc <= acc - term;
            end else if (step == STEP_W'(1)) begin
              acc <= term;
            end else begin
              acc <= acc + term;
            end
          end
          if (step == STEP_W'(8)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (acc[ACC_W-1]) begin
            best_t    <= cur_t;
            best_c    <= cur_c;
            best_slot <= idx;
          end
          if (last_slot) begin
            state <= S_FINAL;
          end else begin
            idx   <= idx + SLOT_W'(1);
            state <= S_READ;
          end
        end
        S_FINAL: begin
          axis <= 1'b0;
          step <= '0;
          state <= found ? S_SCALE : S_EMIT;
        end
        S_SCALE: begin
          // num = |d| * best_t from two partial products
          step <= step + STEP_W'(1);
          if (step == STEP_W'(1)) begin
            num <= NUM_W'(prod[2*HW-1:0]);
          end else if (step == STEP_W'(2)) begin
            num   <= num + (NUM_W'(prod[2*HW-1:0]) << HW);
            dsor  <= NUM_W'(best_c) << (QB - 1);
            quo   <= '0;
            step  <= STEP_W'(QB - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            num <= num - dsor;
          end
          quo  <= qf;
          dsor <= dsor >> 1;
          step <= step - STEP_W'(1);
          if (step == '0) begin
            if (axis) begin
              hy    <= CW'(base + off);
              state <= S_EMIT;
            end else begin
              hx    <= CW'(base + off);
              axis  <= 1'b1;
              step  <= '0;
              state <= S_SCALE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid    <= 1'b1;
            result.hit      <= found;
            result.hit_x    <= found ? hx : '0;
            result.hit_y    <= found ? hy : '0;
            result.hit_slot <= found ? SW_W'(best_slot) : '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/rsnh_checker.sv
// port-level checks of ray_segment_nearest_hit, bound to the top level
// depends on rsnh_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsnh_checker (
  input logic              clk,
  input logic              rst,
  input rsnh_pkg::item_t   item,
  input logic              item_valid,
  input logic              item_stall,
  input rsnh_pkg::result_t result,
  input logic              result_valid,
  input logic              result_stall
);

  // table clearing keeps the input closed right after reset
  `ASSERT_NEXT_ALWAYS(a_clear_after_reset, rst, item_stall)
  // a ray word keeps the block busy
  `ASSERT_NEXT(a_ray_busy, item_valid && !item_stall && item.cmd == rsnh_pkg::CMD_RAY, item_stall)
  // a miss carries zero fields
  `ASSERT_SAME(a_miss_zero, result_valid && !result.hit, result.hit_x == '0 && result.hit_y == '0 && result.hit_slot == '0)
  `ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid)
  `ASSERT_NEXT(a_out_stable, result_valid && result_stall, $stable(result))

endmodule

bind ray_segment_nearest_hit rsnh_checker u_rsnh_checker (.*);
